FILE: hdl/obb_pkg.sv
// ---------------------------------------------------------------------------
// obb_pkg
// Shared constants for the oriented box overlap test.
// ---------------------------------------------------------------------------
package obb_pkg;

    localparam int COORD_BITS_DEF     = 20;
    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int ANGLE_STEPS_DEF    = 360;

    // angle fields are fixed at 9 bits
    localparam int ANGLE_W    = 9;
    localparam int ANGLE_SPAN = 1 << ANGLE_W;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'sd1073741824;

endpackage

FILE: hdl/oriented_box_overlap_test.sv
// ---------------------------------------------------------------------------
// oriented_box_overlap_test
// Six-stage pipelined 2-D separating axis test on two oriented rectangles.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle while in_stall is low; the six stages
// advance together. A stalled output word parks in a skid register and
// in_stall comes from that register.
// Reset: rst_n clears all stage valid bits and the skid flag; no word is in
// flight after reset.
// Sine/cosine come from a constant table indexed by the in-quadrant angle.
module oriented_box_overlap_test #(
    parameter int COORD_BITS     = obb_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF,
    parameter int ANGLE_STEPS    = obb_pkg::ANGLE_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_BITS-1:0]       a_center_x,
    input  logic signed [COORD_BITS-1:0]       a_center_y,
    input  logic        [COORD_BITS-2:0]       a_width,
    input  logic        [COORD_BITS-2:0]       a_height,
    input  logic        [obb_pkg::ANGLE_W-1:0] a_angle,
    input  logic signed [COORD_BITS-1:0]       b_center_x,
    input  logic signed [COORD_BITS-1:0]       b_center_y,
    input  logic        [COORD_BITS-2:0]       b_width,
    input  logic        [COORD_BITS-2:0]       b_height,
    input  logic        [obb_pkg::ANGLE_W-1:0] b_angle,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               collide
);
    import obb_pkg::*;

    localparam int F    = TRIG_FRAC_BITS;
    localparam int LN   = COORD_BITS - 1;         // edge length width
    localparam int DW   = COORD_BITS + 1;         // center difference
    localparam int TW   = F + 2;                  // signed Q1.F trig
    localparam int RBW  = $clog2(ANGLE_STEPS);    // reduced angle
    localparam int TQW  = RBW + 2;                // four times reduced angle
    localparam int PW   = DW + TW;                // d * trig product
    localparam int LFW  = PW + 2;                 // 2*|projection|
    localparam int PPW  = 2 * TW;                 // trig * trig product
    localparam int DOTW = PPW + 1;
    localparam int RDW  = F + 3;                  // rounded |dot|
    localparam int MW   = LN + RDW;               // length * rounded dot
    localparam int CMPW = LFW + 1;
    localparam int RW   = (RBW > ANGLE_W) ? RBW : ANGLE_W;
    localparam int MOD_SUBS = (ANGLE_SPAN - 1) / ANGLE_STEPS;

    localparam logic [TQW-1:0] N1 = TQW'(ANGLE_STEPS);
    localparam logic [TQW-1:0] N2 = TQW'(2 * ANGLE_STEPS);
    localparam logic [TQW-1:0] N3 = TQW'(3 * ANGLE_STEPS);
    localparam logic [DOTW-1:0] HALF = DOTW'(1) << (F - 1);
    localparam logic [RW:0] STEPS_RW = (RW+1)'(ANGLE_STEPS);

    // -------------------------------------------------------------------
    // Constant tables
    // -------------------------------------------------------------------
    function automatic longint to_qf(input longint v);
        longint c;
        c = v;
        if (c < 0) c = 0;
        if (c > ONE_Q30) c = ONE_Q30;
        return (c + (longint'(1) << (29 - F))) >>> (30 - F);
    endfunction

    // {sin, cos} in the first quadrant, each 0..2^F
    function automatic logic [2*F+1:0] trig_entry(input int unsigned rem);
        longint unsigned x, x2, ts, tc;
        longint s, c, sq, cq;
        x  = longint'(rem) * PI_Q30 / (2 * ANGLE_STEPS);
        x2 = (x * x) >> 30;
        ts = x;
        tc = ONE_Q30;
        s  = longint'(x);
        c  = ONE_Q30;
        // first term plus seven more series terms, signs alternating
        tc = ((tc * x2) >> 30) / 2;   ts = ((ts * x2) >> 30) / 6;
        s  = s - longint'(ts);        c  = c - longint'(tc);
        tc = ((tc * x2) >> 30) / 12;  ts = ((ts * x2) >> 30) / 20;
        s  = s + longint'(ts);        c  = c + longint'(tc);
        tc = ((tc * x2) >> 30) / 30;  ts = ((ts * x2) >> 30) / 42;
        s  = s - longint'(ts);        c  = c - longint'(tc);
        tc = ((tc * x2) >> 30) / 56;  ts = ((ts * x2) >> 30) / 72;
        s  = s + longint'(ts);        c  = c + longint'(tc);
        tc = ((tc * x2) >> 30) / 90;  ts = ((ts * x2) >> 30) / 110;
        s  = s - longint'(ts);        c  = c - longint'(tc);
        tc = ((tc * x2) >> 30) / 132; ts = ((ts * x2) >> 30) / 156;
        s  = s + longint'(ts);        c  = c + longint'(tc);
        tc = ((tc * x2) >> 30) / 182; ts = ((ts * x2) >> 30) / 210;
        s  = s - longint'(ts);        c  = c - longint'(tc);
        sq = to_qf(s);
        cq = to_qf(c);
        return {sq[F:0], cq[F:0]};
    endfunction

    logic [2*F+1:0]   trig_rom [ANGLE_STEPS];

    for (genvar gj = 0; gj < ANGLE_STEPS; gj++)
    begin : g_trig
        assign trig_rom[gj] = trig_entry(gj);
    end

    // -------------------------------------------------------------------
    // Pipeline control: all stages move together, skid word at the output
    // -------------------------------------------------------------------
    logic [5:0] v_reg;
    logic       adv;
    logic       skid_full_reg, skid_full_next;
    logic       skid_collide_reg;
    logic       collide_reg;

    assign adv            = !skid_full_reg;
    assign in_stall       = skid_full_reg;
    assign out_valid      = skid_full_reg || v_reg[5];
    assign skid_full_next = out_stall && (skid_full_reg || v_reg[5]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
            if (adv)
                v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && v_reg[5] && out_stall)
            skid_collide_reg <= collide_reg;
    end

    // -------------------------------------------------------------------
    // Stage 1: angle reduction, center difference
    // -------------------------------------------------------------------
    function automatic logic [RBW-1:0] reduce_angle(input logic [ANGLE_W-1:0] ang);
        logic [RW:0] r;
        r = (RW+1)'(ang);
        for (int i = 0; i < MOD_SUBS; i++)
        begin
            if (r >= STEPS_RW)
                r = r - STEPS_RW;
        end
        return RBW'(r);
    endfunction

    logic        [RBW-1:0] ra_reg, rb_reg;
    logic signed [DW-1:0]  dx_reg, dy_reg;
    logic        [LN-1:0]  aw1_reg, ah1_reg, bw1_reg, bh1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_reg  <= reduce_angle(a_angle);
            rb_reg  <= reduce_angle(b_angle);
            dx_reg  <= DW'(b_center_x) - DW'(a_center_x);
            dy_reg  <= DW'(b_center_y) - DW'(a_center_y);
            aw1_reg <= a_width;
            ah1_reg <= a_height;
            bw1_reg <= b_width;
            bh1_reg <= b_height;
        end
    end

    // -------------------------------------------------------------------
    // Stage 2: quadrant split, trig lookup
    // -------------------------------------------------------------------
    logic [TQW-1:0] ta, tb;
    logic [1:0]     qa, qb;
    logic [TQW-1:0] rema, remb;
    logic [2*F+1:0] ea, eb;
    logic signed [TW-1:0] sa_next, ca_next, sb_next, cb_next;
    logic signed [TW-1:0] sa_reg, ca_reg, sb_reg, cb_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic        [LN-1:0] aw2_reg, ah2_reg, bw2_reg, bh2_reg;

    always_comb
    begin
        ta = {ra_reg, 2'b00};
        tb = {rb_reg, 2'b00};
        if (ta >= N3)      begin qa = 2'd3; rema = ta - N3; end
        else if (ta >= N2) begin qa = 2'd2; rema = ta - N2; end
        else if (ta >= N1) begin qa = 2'd1; rema = ta - N1; end
        else               begin qa = 2'd0; rema = ta;      end
        if (tb >= N3)      begin qb = 2'd3; remb = tb - N3; end
        else if (tb >= N2) begin qb = 2'd2; remb = tb - N2; end
        else if (tb >= N1) begin qb = 2'd1; remb = tb - N1; end
        else               begin qb = 2'd0; remb = tb;      end
        ea = trig_rom[rema[RBW-1:0]];
        eb = trig_rom[remb[RBW-1:0]];
        case (qa)
            2'd0:    begin sa_next =  TW'(ea[2*F+1:F+1]); ca_next =  TW'(ea[F:0]); end
            2'd1:    begin sa_next =  TW'(ea[F:0]);       ca_next = -TW'(ea[2*F+1:F+1]); end
            2'd2:    begin sa_next = -TW'(ea[2*F+1:F+1]); ca_next = -TW'(ea[F:0]); end
            default: begin sa_next = -TW'(ea[F:0]);       ca_next =  TW'(ea[2*F+1:F+1]); end
        endcase
        case (qb)
            2'd0:    begin sb_next =  TW'(eb[2*F+1:F+1]); cb_next =  TW'(eb[F:0]); end
            2'd1:    begin sb_next =  TW'(eb[F:0]);       cb_next = -TW'(eb[2*F+1:F+1]); end
            2'd2:    begin sb_next = -TW'(eb[2*F+1:F+1]); cb_next = -TW'(eb[F:0]); end
            default: begin sb_next = -TW'(eb[F:0]);       cb_next =  TW'(eb[2*F+1:F+1]); end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg  <= sa_next;
            ca_reg  <= ca_next;
            sb_reg  <= sb_next;
            cb_reg  <= cb_next;
            dx2_reg <= dx_reg;
            dy2_reg <= dy_reg;
            aw2_reg <= aw1_reg;
            ah2_reg <= ah1_reg;
            bw2_reg <= bw1_reg;
            bh2_reg <= bh1_reg;
        end
    end

    // -------------------------------------------------------------------
    // Stage 3: products
    // -------------------------------------------------------------------
    logic signed [PW-1:0]  dxca_reg, dysa_reg, dxsa_reg, dyca_reg;
    logic signed [PW-1:0]  dxcb_reg, dysb_reg, dxsb_reg, dycb_reg;
    logic signed [PPW-1:0] cacb_reg, sasb_reg, casb_reg, sacb_reg;
    logic        [LN-1:0]  aw3_reg, ah3_reg, bw3_reg, bh3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxca_reg <= PW'(dx2_reg) * PW'(ca_reg);
            dysa_reg <= PW'(dy2_reg) * PW'(sa_reg);
            dxsa_reg <= PW'(dx2_reg) * PW'(sa_reg);
            dyca_reg <= PW'(dy2_reg) * PW'(ca_reg);
            dxcb_reg <= PW'(dx2_reg) * PW'(cb_reg);
            dysb_reg <= PW'(dy2_reg) * PW'(sb_reg);
            dxsb_reg <= PW'(dx2_reg) * PW'(sb_reg);
            dycb_reg <= PW'(dy2_reg) * PW'(cb_reg);
            cacb_reg <= PPW'(ca_reg) * PPW'(cb_reg);
            sasb_reg <= PPW'(sa_reg) * PPW'(sb_reg);
            casb_reg <= PPW'(ca_reg) * PPW'(sb_reg);
            sacb_reg <= PPW'(sa_reg) * PPW'(cb_reg);
            aw3_reg  <= aw2_reg;
            ah3_reg  <= ah2_reg;
            bw3_reg  <= bw2_reg;
            bh3_reg  <= bh2_reg;
        end
    end

    // -------------------------------------------------------------------
    // Stage 4: projections, cross dots, rounding
    // -------------------------------------------------------------------
    logic signed [PW:0]    pj_ua, pj_va, pj_ub, pj_vb;
    logic signed [DOTW-1:0] dot_p, dot_q;
    logic        [DOTW-1:0] abs_p, abs_q;
    logic        [LFW-1:0] l_ua_reg, l_va_reg, l_ub_reg, l_vb_reg;
    logic        [RDW-1:0] rp_reg, rq_reg;
    logic        [LN-1:0]  aw4_reg, ah4_reg, bw4_reg, bh4_reg;

    always_comb
    begin
        pj_ua = (PW+1)'(dxca_reg) - (PW+1)'(dysa_reg);
        pj_va = (PW+1)'(dxsa_reg) + (PW+1)'(dyca_reg);
        pj_ub = (PW+1)'(dxcb_reg) - (PW+1)'(dysb_reg);
        pj_vb = (PW+1)'(dxsb_reg) + (PW+1)'(dycb_reg);
        dot_p = DOTW'(cacb_reg) + DOTW'(sasb_reg);
        dot_q = DOTW'(casb_reg) - DOTW'(sacb_reg);
        abs_p = dot_p[DOTW-1] ? DOTW'(0) - dot_p : dot_p;
        abs_q = dot_q[DOTW-1] ? DOTW'(0) - dot_q : dot_q;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_ua_reg <= LFW'(pj_ua[PW] ? -pj_ua : pj_ua) << 1;
            l_va_reg <= LFW'(pj_va[PW] ? -pj_va : pj_va) << 1;
            l_ub_reg <= LFW'(pj_ub[PW] ? -pj_ub : pj_ub) << 1;
            l_vb_reg <= LFW'(pj_vb[PW] ? -pj_vb : pj_vb) << 1;
            rp_reg   <= RDW'((abs_p + HALF) >> F);
            rq_reg   <= RDW'((abs_q + HALF) >> F);
            aw4_reg  <= aw3_reg;
            ah4_reg  <= ah3_reg;
            bw4_reg  <= bw3_reg;
            bh4_reg  <= bh3_reg;
        end
    end

    // -------------------------------------------------------------------
    // Stage 5: projected extents
    // -------------------------------------------------------------------
    logic [MW-1:0]  bwp_reg, bhq_reg, bwq_reg, bhp_reg;
    logic [MW-1:0]  awp_reg, ahq_reg, awq_reg, ahp_reg;
    logic [LFW-1:0] l_ua5_reg, l_va5_reg, l_ub5_reg, l_vb5_reg;
    logic [LN-1:0]  aw5_reg, ah5_reg, bw5_reg, bh5_reg;
    logic           lz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bwp_reg   <= MW'(bw4_reg) * MW'(rp_reg);
            bhq_reg   <= MW'(bh4_reg) * MW'(rq_reg);
            bwq_reg   <= MW'(bw4_reg) * MW'(rq_reg);
            bhp_reg   <= MW'(bh4_reg) * MW'(rp_reg);
            awp_reg   <= MW'(aw4_reg) * MW'(rp_reg);
            ahq_reg   <= MW'(ah4_reg) * MW'(rq_reg);
            awq_reg   <= MW'(aw4_reg) * MW'(rq_reg);
            ahp_reg   <= MW'(ah4_reg) * MW'(rp_reg);
            l_ua5_reg <= l_ua_reg;
            l_va5_reg <= l_va_reg;
            l_ub5_reg <= l_ub_reg;
            l_vb5_reg <= l_vb_reg;
            lz_reg    <= (l_ua_reg == '0) && (l_va_reg == '0)
                         && (l_ub_reg == '0) && (l_vb_reg == '0);
            aw5_reg   <= aw4_reg;
            ah5_reg   <= ah4_reg;
            bw5_reg   <= bw4_reg;
            bh5_reg   <= bh4_reg;
        end
    end

    // -------------------------------------------------------------------
    // Stage 6: interval compare on all four axes
    // -------------------------------------------------------------------
    logic [CMPW-1:0] r_ua, r_va, r_ub, r_vb;
    logic            collide_next;

    always_comb
    begin
        r_ua = (CMPW'(aw5_reg) << F) + CMPW'(bwp_reg) + CMPW'(bhq_reg);
        r_va = (CMPW'(ah5_reg) << F) + CMPW'(bwq_reg) + CMPW'(bhp_reg);
        r_ub = (CMPW'(bw5_reg) << F) + CMPW'(awp_reg) + CMPW'(ahq_reg);
        r_vb = (CMPW'(bh5_reg) << F) + CMPW'(awq_reg) + CMPW'(ahp_reg);
        collide_next = (CMPW'(l_ua5_reg) <= r_ua) && (CMPW'(l_va5_reg) <= r_va)
                       && (CMPW'(l_ub5_reg) <= r_ub) && (CMPW'(l_vb5_reg) <= r_vb);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            collide_reg <= collide_next;
    end

    assign collide = skid_full_reg ? skid_collide_reg : collide_reg;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> v_reg[5:1] == $past(v_reg[4:0]))
        else $error("stage valid bits did not shift on advance");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg) && $stable(collide_reg))
        else $error("pipeline moved while skid word waits");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(collide))
        else $error("stalled output word changed");

    a_same_center: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v_reg[4] && lz_reg |=> collide_reg)
        else $error("coincident centers must collide");

endmodule
